// File: rtl/sck_pkg.sv
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types, constants and arithmetic step functions for the cubic spline
// kernel and gradient pipeline.
// ----------------------------------------------------------------------------
package sck_pkg;

  localparam int CFG_IDX_W       = 2;
  localparam int STEPS_PER_STAGE = 2;

  // square root: 32 result bits, one per step
  localparam int SQRT_BITS   = 32;
  localparam int SQRT_STAGES = SQRT_BITS / STEPS_PER_STAGE;
  // q = rl*2^16/h: 18 quotient bits, top one always zero in support
  localparam int Q_BITS      = 18;
  localparam int Q_STAGES    = Q_BITS / STEPS_PER_STAGE;
  // v = c*|r|/rl: 48 quotient bits, larger values saturate
  localparam int V_BITS      = 48;
  localparam int V_STAGES    = V_BITS / STEPS_PER_STAGE;
  // m = v*2^16/h: 32 quotient bits
  localparam int M_BITS      = 32;
  localparam int M_STAGES    = M_BITS / STEPS_PER_STAGE;

  localparam int FRONT_REGS = 3 + SQRT_STAGES + 1;
  localparam int POLY_REGS  = 1 + Q_STAGES + 5;
  localparam int GRAD_REGS  = 2 + V_STAGES + 1 + M_STAGES + 1;
  localparam int PIPE_DEPTH = FRONT_REGS + POLY_REGS + GRAD_REGS;

  localparam logic [31:0] RST_LENGTH_SCALE   = 32'd65536;
  localparam logic [31:0] RST_SUPPORT_RADIUS = 32'd65536;
  localparam logic [31:0] RST_VALUE_NORM     = 32'd166886;
  localparam logic [31:0] RST_GRAD_NORM      = 32'd1001316;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH_SCALE   = 2'd0,
    REG_SUPPORT_RADIUS = 2'd1,
    REG_VALUE_NORM     = 2'd2,
    REG_GRAD_NORM      = 2'd3
  } sck_reg_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
  } sck_in_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
  } sck_out_t;

  typedef struct packed {
    logic [31:0] length_scale;
    logic [31:0] support_radius;
    logic [31:0] value_norm;
    logic [31:0] grad_norm;
  } sck_cfg_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [47:0]      rl;
  } sck_geo_t;

  typedef struct packed {
    logic [31:0]      weight;
    logic [31:0]      coef;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [31:0]      rl;
    logic             grad_en;
  } sck_mid_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic        qbit;
    logic [31:0] rem;
  } div_step_t;

  // one digit of the restoring square root, two radicand bits in
  function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
    logic [34:0] t;
    logic [34:0] trial;
    sqrt_acc_t   r;
    t     = {a.rem, pair};
    trial = {1'b0, a.root, 2'b01};
    if (t >= trial) begin
      r.rem  = 33'(t - trial);
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = t[32:0];
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one bit of restoring division, partial remainder stays below the divisor
  function automatic div_step_t div_step(input logic [31:0] rem, input logic [31:0] dvsr,
                                         input logic din);
    logic [32:0] t;
    div_step_t   r;
    t = {rem, din};
    if (t >= {1'b0, dvsr}) begin
      r.qbit = 1'b1;
      r.rem  = 32'(t - {1'b0, dvsr});
    end else begin
      r.qbit = 1'b0;
      r.rem  = t[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/sck_front.sv
// ----------------------------------------------------------------------------
// sck_front
// Component magnitudes, squared length, pipelined square root and scaling
// of the distance by the length factor.
// ----------------------------------------------------------------------------
module sck_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sck_pkg::sck_in_t  in_data,
  input  sck_pkg::sck_cfg_t cfg,
  output logic              geo_valid,
  output sck_pkg::sck_geo_t geo
);
  import sck_pkg::*;

  logic [FRONT_REGS-1:0] fv_r;
  logic [2:0][31:0]      raw;
  logic [2:0][31:0]      mag_in;
  logic [2:0]            neg_in;
  logic [2:0][31:0]      mag0_r;
  logic [2:0]            neg0_r;
  logic [2:0][31:0]      mag1_r;
  logic [2:0]            neg1_r;
  logic [2:0][63:0]      sq1_r;
  sqrt_acc_t             sacc_r [SQRT_STAGES+1];
  logic [63:0]           sn_r   [SQRT_STAGES+1];
  logic [2:0][31:0]      smag_r [SQRT_STAGES+1];
  logic [2:0]            sneg_r [SQRT_STAGES+1];
  logic [63:0]           rl_prod;
  sck_geo_t              geo_r;

  assign raw[0] = in_data.disp_x;
  assign raw[1] = in_data.disp_y;
  assign raw[2] = in_data.disp_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = raw[i][31];
      mag_in[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

  assign rl_prod = 64'(sacc_r[SQRT_STAGES].root) * 64'(cfg.length_scale);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[FRONT_REGS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mag0_r <= mag_in;
    neg0_r <= neg_in;
    for (int i = 0; i < 3; i++) begin
      sq1_r[i] <= 64'(mag0_r[i]) * 64'(mag0_r[i]);
    end
    mag1_r <= mag0_r;
    neg1_r <= neg0_r;
    // sum of three squares stays below 2^64
    sacc_r[0] <= '0;
    sn_r[0]   <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    smag_r[0] <= mag1_r;
    sneg_r[0] <= neg1_r;
    geo_r.rl  <= rl_prod[63:16];
    geo_r.mag <= smag_r[SQRT_STAGES];
    geo_r.neg <= sneg_r[SQRT_STAGES];
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_sqrt
    sqrt_acc_t   acc_c;
    logic [63:0] n_c;
    always_comb begin
      acc_c = sacc_r[s];
      n_c   = sn_r[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        acc_c = sqrt_step(acc_c, n_c[63:62]);
        n_c   = {n_c[61:0], 2'b00};
      end
    end
    always_ff @(posedge clk) begin
      sacc_r[s+1] <= acc_c;
      sn_r[s+1]   <= n_c;
      smag_r[s+1] <= smag_r[s];
      sneg_r[s+1] <= sneg_r[s];
    end
  end

  assign geo_valid = fv_r[FRONT_REGS-1];
  assign geo       = geo_r;

endmodule

// File: rtl/sck_poly.sv
// ----------------------------------------------------------------------------
// sck_poly
// Support tests, pipelined q division, kernel polynomial, weight and the
// gradient coefficient.
// ----------------------------------------------------------------------------
module sck_poly (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              geo_valid,
  input  sck_pkg::sck_geo_t geo,
  input  sck_pkg::sck_cfg_t cfg,
  output logic              mid_valid,
  output sck_pkg::sck_mid_t mid
);
  import sck_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [31:0]      rl;
    logic             outside;
    logic             half;
    logic             zero;
  } sck_side_t;

  logic [POLY_REGS-1:0] pv_r;
  sck_side_t            side_in;
  logic [31:0]          qrem_r  [Q_STAGES+1];
  logic [Q_BITS-1:0]    qfeed_r [Q_STAGES+1];
  logic [Q_BITS-1:0]    qquo_r  [Q_STAGES+1];
  sck_side_t            qside_r [Q_STAGES+1];
  logic [16:0]          q_c;
  logic [16:0]          s_c;
  logic [17:0]          d3_c;
  logic [16:0]          p1_s_r;
  logic [33:0]          p1_sq_r;
  logic [34:0]          p1_gh_r;
  sck_side_t            p1_side_r;
  logic [50:0]          p2_cube_r;
  logic [33:0]          p2_sq_r;
  logic [31:0]          p2_gmag_r;
  sck_side_t            p2_side_r;
  logic [50:0]          c6_c;
  logic [50:0]          sq6_c;
  logic [50:0]          poly_c;
  logic [16:0]          p3_p_r;
  logic [15:0]          p3_g_r;
  sck_side_t            p3_side_r;
  logic [48:0]          wprod_c;
  logic [47:0]          cprod_c;
  logic [32:0]          p4_w_r;
  logic [31:0]          p4_coef_r;
  sck_side_t            p4_side_r;
  sck_mid_t             mid_r;

  always_comb begin
    side_in.mag     = geo.mag;
    side_in.neg     = geo.neg;
    side_in.rl      = geo.rl[31:0];
    side_in.outside = (cfg.support_radius == 32'd0) || (geo.rl > {16'h0, cfg.support_radius});
    side_in.half    = {geo.rl, 1'b0} <= {17'h0, cfg.support_radius};
    side_in.zero    = geo.rl == 48'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[POLY_REGS-2:0], geo_valid};
    end
  end

  // dividend is rl*2^16, the partial remainder starts from rl/4
  always_ff @(posedge clk) begin
    qrem_r[0]  <= side_in.outside ? 32'd0 : {2'b00, geo.rl[31:2]};
    qfeed_r[0] <= {geo.rl[1:0], 16'h0};
    qquo_r[0]  <= '0;
    qside_r[0] <= side_in;
  end

  for (genvar s = 0; s < Q_STAGES; s++) begin : g_qdiv
    logic [31:0]       rem_c;
    logic [Q_BITS-1:0] feed_c;
    logic [Q_BITS-1:0] quo_c;
    div_step_t         st;
    always_comb begin
      rem_c  = qrem_r[s];
      feed_c = qfeed_r[s];
      quo_c  = qquo_r[s];
      st     = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        st     = div_step(rem_c, cfg.support_radius, feed_c[Q_BITS-1]);
        rem_c  = st.rem;
        quo_c  = {quo_c[Q_BITS-2:0], st.qbit};
        feed_c = {feed_c[Q_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      qrem_r[s+1]  <= rem_c;
      qfeed_r[s+1] <= feed_c;
      qquo_r[s+1]  <= quo_c;
      qside_r[s+1] <= qside_r[s];
    end
  end

  always_comb begin
    q_c    = qquo_r[Q_STAGES][16:0];
    s_c    = qside_r[Q_STAGES].half ? q_c : 17'(17'd65536 - q_c);
    d3_c   = 18'(18'd131072 - ({1'b0, q_c} + {q_c, 1'b0}));
    c6_c   = p2_cube_r * 51'd6;
    sq6_c  = 51'({p2_sq_r, 16'h0}) * 51'd6;
    poly_c = p2_side_r.half ? (c6_c + (51'd1 << 48) - sq6_c) : {p2_cube_r[49:0], 1'b0};
    wprod_c = 49'(cfg.value_norm) * 49'(p3_p_r);
    cprod_c = 48'(cfg.grad_norm) * 48'(p3_g_r);
  end

  always_ff @(posedge clk) begin
    // q or 1-q, squared; q(2-3q) in Q32
    p1_s_r    <= s_c;
    p1_sq_r   <= 34'(s_c) * 34'(s_c);
    p1_gh_r   <= 35'(q_c) * 35'(d3_c);
    p1_side_r <= qside_r[Q_STAGES];

    p2_cube_r <= 51'(p1_sq_r) * 51'(p1_s_r);
    p2_sq_r   <= p1_sq_r;
    p2_gmag_r <= p1_side_r.half ? p1_gh_r[31:0] : p1_sq_r[31:0];
    p2_side_r <= p1_side_r;

    p3_p_r    <= poly_c[48:32];
    p3_g_r    <= p2_gmag_r[31:16];
    p3_side_r <= p2_side_r;

    p4_w_r    <= wprod_c[48:16];
    p4_coef_r <= cprod_c[47:16];
    p4_side_r <= p3_side_r;

    if (p4_side_r.outside) begin
      mid_r.weight <= 32'd0;
    end else if (p4_w_r[32] || p4_w_r[31]) begin
      mid_r.weight <= SAT_POS;
    end else begin
      mid_r.weight <= p4_w_r[31:0];
    end
    mid_r.coef    <= p4_coef_r;
    mid_r.mag     <= p4_side_r.mag;
    mid_r.neg     <= p4_side_r.neg;
    mid_r.rl      <= p4_side_r.rl;
    mid_r.grad_en <= !p4_side_r.outside && !p4_side_r.zero;
  end

  assign mid_valid = pv_r[POLY_REGS-1];
  assign mid       = mid_r;

endmodule

// File: rtl/sck_grad.sv
// ----------------------------------------------------------------------------
// sck_grad
// Three gradient lanes: coefficient times component, division by rl and by
// the radius, saturation and sign, packed with the weight.
// ----------------------------------------------------------------------------
module sck_grad (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mid_valid,
  input  sck_pkg::sck_mid_t mid,
  input  sck_pkg::sck_cfg_t cfg,
  output logic              res_valid,
  output sck_pkg::sck_out_t res
);
  import sck_pkg::*;

  typedef struct packed {
    logic [31:0] weight;
    logic [2:0]  neg;
    logic [31:0] rl;
    logic        grad_en;
  } sck_gside_t;

  logic [GRAD_REGS-1:0] gv_r;
  sck_gside_t           gside_in;
  logic [2:0][63:0]     x_r;
  sck_gside_t           g0_side_r;
  logic [2:0][31:0]     vrem_r  [V_STAGES+1];
  logic [2:0][47:0]     vfeed_r [V_STAGES+1];
  logic [2:0][47:0]     vquo_r  [V_STAGES+1];
  logic [2:0]           vovf_r  [V_STAGES+1];
  sck_gside_t           vside_r [V_STAGES+1];
  logic [2:0][31:0]     mrem_r  [M_STAGES+1];
  logic [2:0][31:0]     mfeed_r [M_STAGES+1];
  logic [2:0][31:0]     mquo_r  [M_STAGES+1];
  logic [2:0]           msat_r  [M_STAGES+1];
  sck_gside_t           mside_r [M_STAGES+1];
  logic [2:0][31:0]     gcomp_c;
  sck_out_t             res_r;

  always_comb begin
    gside_in.weight  = mid.weight;
    gside_in.neg     = mid.neg;
    gside_in.rl      = mid.rl;
    gside_in.grad_en = mid.grad_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= '0;
    end else begin
      gv_r <= {gv_r[GRAD_REGS-2:0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      x_r[i] <= 64'(mid.coef) * 64'(mid.mag[i]);
    end
    g0_side_r <= gside_in;
    // a quotient of 2^48 or more saturates anyway
    for (int i = 0; i < 3; i++) begin
      vrem_r[0][i]  <= {16'h0, x_r[i][63:48]};
      vfeed_r[0][i] <= x_r[i][47:0];
      vquo_r[0][i]  <= '0;
      vovf_r[0][i]  <= {16'h0, x_r[i][63:48]} >= g0_side_r.rl;
    end
    vside_r[0] <= g0_side_r;
  end

  for (genvar s = 0; s < V_STAGES; s++) begin : g_vdiv
    logic [2:0][31:0] rem_c;
    logic [2:0][47:0] feed_c;
    logic [2:0][47:0] quo_c;
    div_step_t        st;
    always_comb begin
      rem_c  = vrem_r[s];
      feed_c = vfeed_r[s];
      quo_c  = vquo_r[s];
      st     = '0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          st        = div_step(rem_c[i], vside_r[s].rl, feed_c[i][47]);
          rem_c[i]  = st.rem;
          quo_c[i]  = {quo_c[i][46:0], st.qbit};
          feed_c[i] = {feed_c[i][46:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      vrem_r[s+1]  <= rem_c;
      vfeed_r[s+1] <= feed_c;
      vquo_r[s+1]  <= quo_c;
      vovf_r[s+1]  <= vovf_r[s];
      vside_r[s+1] <= vside_r[s];
    end
  end

  // v*2^16/h needs 32 bits only when v < h*2^16
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mrem_r[0][i]  <= vquo_r[V_STAGES][i][47:16];
      mfeed_r[0][i] <= {vquo_r[V_STAGES][i][15:0], 16'h0};
      mquo_r[0][i]  <= '0;
      msat_r[0][i]  <= vovf_r[V_STAGES][i] ||
                       (vquo_r[V_STAGES][i] >= {cfg.support_radius, 16'h0});
    end
    mside_r[0] <= vside_r[V_STAGES];
  end

  for (genvar s = 0; s < M_STAGES; s++) begin : g_mdiv
    logic [2:0][31:0] rem_c;
    logic [2:0][31:0] feed_c;
    logic [2:0][31:0] quo_c;
    div_step_t        st;
    always_comb begin
      rem_c  = mrem_r[s];
      feed_c = mfeed_r[s];
      quo_c  = mquo_r[s];
      st     = '0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          st        = div_step(rem_c[i], cfg.support_radius, feed_c[i][31]);
          rem_c[i]  = st.rem;
          quo_c[i]  = {quo_c[i][30:0], st.qbit};
          feed_c[i] = {feed_c[i][30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      mrem_r[s+1]  <= rem_c;
      mfeed_r[s+1] <= feed_c;
      mquo_r[s+1]  <= quo_c;
      msat_r[s+1]  <= msat_r[s];
      mside_r[s+1] <= mside_r[s];
    end
  end

  // gradient points against r, magnitude truncated toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!mside_r[M_STAGES].grad_en) begin
        gcomp_c[i] = 32'd0;
      end else if (msat_r[M_STAGES][i]) begin
        gcomp_c[i] = mside_r[M_STAGES].neg[i] ? SAT_POS : SAT_NEG;
      end else if (!mside_r[M_STAGES].neg[i] && (mquo_r[M_STAGES][i] != 32'd0)) begin
        gcomp_c[i] = (mquo_r[M_STAGES][i] > SAT_NEG) ? SAT_NEG
                                                     : (~mquo_r[M_STAGES][i] + 32'd1);
      end else begin
        gcomp_c[i] = (mquo_r[M_STAGES][i] > SAT_POS) ? SAT_POS : mquo_r[M_STAGES][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r.weight <= mside_r[M_STAGES].weight;
    res_r.grad_x <= gcomp_c[0];
    res_r.grad_y <= gcomp_c[1];
    res_r.grad_z <= gcomp_c[2];
  end

  assign res_valid = gv_r[GRAD_REGS-1];
  assign res       = res_r;

endmodule

// File: rtl/sph_cubic_kernel_and_gradient_core.sv
// ----------------------------------------------------------------------------
// sph_cubic_kernel_and_gradient_core
// Cubic spline SPH kernel value and gradient for one displacement vector.
// ----------------------------------------------------------------------------
// Takes one displacement beat per clock whenever start is high and busy is
// low; busy is high only while reset is held. Each beat returns exactly one
// result, marked by out_strobe for one cycle. The pipeline is made of
// bit-serial stages: a 32-step square root, an 18-step division for q and,
// per gradient lane, 48-step and 32-step divisions, all at two steps per
// register stage. Results cannot be held off.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no beat is in flight.
module sph_cubic_kernel_and_gradient_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  sck_pkg::sck_in_t               in_data,
  output logic                           out_strobe,
  output sck_pkg::sck_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [sck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import sck_pkg::*;

  sck_cfg_t cfg_r;
  logic     in_valid;
  logic     geo_valid;
  sck_geo_t geo;
  logic     mid_valid;
  sck_mid_t mid;

  assign busy     = !rst_n;
  assign in_valid = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.length_scale   <= RST_LENGTH_SCALE;
      cfg_r.support_radius <= RST_SUPPORT_RADIUS;
      cfg_r.value_norm     <= RST_VALUE_NORM;
      cfg_r.grad_norm      <= RST_GRAD_NORM;
    end else if (cfg_we) begin
      unique case (sck_reg_t'(cfg_index))
        REG_LENGTH_SCALE:   cfg_r.length_scale   <= cfg_data;
        REG_SUPPORT_RADIUS: cfg_r.support_radius <= cfg_data;
        REG_VALUE_NORM:     cfg_r.value_norm     <= cfg_data;
        REG_GRAD_NORM:      cfg_r.grad_norm      <= cfg_data;
        default:            cfg_r.grad_norm      <= cfg_r.grad_norm;
      endcase
    end
  end

  sck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  sck_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .geo_valid (geo_valid),
    .geo       (geo),
    .cfg       (cfg_r),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  sck_grad u_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid       (mid),
    .cfg       (cfg_r),
    .res_valid (out_strobe),
    .res       (out_data)
  );

`ifndef SYNTHESIS
  a_beat_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_strobe)
    else $error("accepted beat did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a matching input beat");

  a_weight_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !out_data.weight[31])
    else $error("kernel weight came out negative");
`endif

endmodule
